[hdl/ksr_pkg.sv]
package ksr_pkg;

    // Request modes
    localparam logic [2:0] MODE_TIME   = 3'd0;
    localparam logic [2:0] MODE_KEY    = 3'd1;
    localparam logic [2:0] MODE_BUTTON = 3'd2;
    localparam logic [2:0] MODE_TICK   = 3'd3;
    localparam logic [2:0] MODE_QUERY  = 3'd4;
    localparam logic [2:0] MODE_TAKE   = 3'd5;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_STEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_FLOOR   = 2'd2;

    // Reset values of the delay settings (ms)
    localparam logic [15:0] RST_INITIAL_DELAY = 16'd300;
    localparam logic [15:0] RST_DELAY_STEP    = 16'd80;
    localparam logic [15:0] RST_DELAY_FLOOR   = 16'd20;

    typedef struct packed {
        logic [15:0] initial_delay;
        logic [15:0] delay_step;
        logic [15:0] delay_floor;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  key_code;
        logic        pressed;
        logic        button_index;
        logic [31:0] now_ms;
    } t_req;

    typedef struct packed {
        logic       key_is_down;
        logic       key_just_pressed;
        logic       left_clicked;
        logic       right_clicked;
        logic [7:0] pending_key;
    } t_res;

endpackage

[hdl/key_state_typematic_repeat_top.sv]
// Key and mouse button state tracker with typematic auto-repeat.
// Request channel: drive the request fields with start high; a request is
// taken at every rising edge where start is high and busy is low. busy
// stays low, so a request can be issued in every cycle.
// Each request yields exactly one result, shown on the o_ result ports
// with o_done high for one cycle. The request is registered, then the state
// store is updated and the result is registered on the next edge, which
// raises o_done.
// Throughput is one request per cycle, set by the single pass of
// state-update logic between the request register and the result register.
// Results cannot be held off by the receiver; capture them on o_done.
// Configuration: write initial delay, delay step and delay floor through
// i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data; o_cfg_ready is
// always high. Write only while no request is in flight.
// Reset (synchronous, active low) clears every key and button bit, the
// held key and the timers, sets the delay settings to 300, 80 and 20 ms and
// the repeat delay to 300 ms.
module key_state_typematic_repeat_top #(
    parameter int NUM_KEYS    = 255,
    parameter int NUM_BUTTONS = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    i_mode,
    input  logic [7:0]                    i_key_code,
    input  logic                          i_pressed,
    input  logic                          i_button_index,
    input  logic [31:0]                   i_now_ms,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ksr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    output logic                          o_done,
    output logic                          o_key_is_down,
    output logic                          o_key_just_pressed,
    output logic                          o_left_clicked,
    output logic                          o_right_clicked,
    output logic [7:0]                    o_pending_key
);

    logic          r_req_valid;
    ksr_pkg::t_req r_req;
    ksr_pkg::t_cfg r_cfg;
    ksr_pkg::t_res res;
    ksr_pkg::t_res r_res;
    logic          r_done;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_delay <= ksr_pkg::RST_INITIAL_DELAY;
            r_cfg.delay_step    <= ksr_pkg::RST_DELAY_STEP;
            r_cfg.delay_floor   <= ksr_pkg::RST_DELAY_FLOOR;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ksr_pkg::CFG_INITIAL_DELAY: r_cfg.initial_delay <= i_cfg_data;
                ksr_pkg::CFG_DELAY_STEP:    r_cfg.delay_step    <= i_cfg_data;
                ksr_pkg::CFG_DELAY_FLOOR:   r_cfg.delay_floor   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else begin
            r_req_valid <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_req.mode         <= i_mode;
            r_req.key_code     <= i_key_code;
            r_req.pressed      <= i_pressed;
            r_req.button_index <= i_button_index;
            r_req.now_ms       <= i_now_ms;
        end
    end

    ksr_state #(
        .NUM_KEYS    (NUM_KEYS),
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (r_req_valid),
        .i_req       (r_req),
        .i_cfg       (r_cfg),
        .o_res       (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_req_valid) begin
            r_res <= res;
        end
    end

    assign o_done             = r_done;
    assign o_key_is_down      = r_res.key_is_down;
    assign o_key_just_pressed = r_res.key_just_pressed;
    assign o_left_clicked     = r_res.left_clicked;
    assign o_right_clicked    = r_res.right_clicked;
    assign o_pending_key      = r_res.pending_key;

    // Every accepted request gives one result on o_done
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("result missing for accepted request");

    // Only queries and takes report nonzero fields
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_valid && r_req.mode != ksr_pkg::MODE_QUERY
            && r_req.mode != ksr_pkg::MODE_TAKE)
        |=> (r_res == '0))
        else $error("nonzero result for non-reporting request");

endmodule

[hdl/ksr_state.sv]
// Key/button state store with typematic repeat timing.
// State updates on the clock edge that ends a request's cycle; the result
// for that request is computed from the state before the update.
module ksr_state #(
    parameter int NUM_KEYS    = 255,
    parameter int NUM_BUTTONS = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  ksr_pkg::t_req i_req,
    input  ksr_pkg::t_cfg i_cfg,
    output ksr_pkg::t_res o_res
);

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic [NUM_KEYS-1:0]    r_key_now, n_key_now;
    logic [NUM_KEYS-1:0]    r_key_before, n_key_before;
    logic [NUM_BUTTONS-1:0] r_btn_now, n_btn_now;
    logic [NUM_BUTTONS-1:0] r_btn_before, n_btn_before;
    logic [7:0]             r_held, n_held;
    logic [31:0]            r_time, n_time;
    logic [31:0]            r_last, n_last;
    logic [15:0]            r_delay, n_delay;

    logic                   code_ok;
    logic [KW-1:0]          kidx;
    logic [32:0]            deadline;
    logic                   rep_due;
    logic [15:0]            shrunk;
    logic [15:0]            delay_rep;
    logic [NUM_BUTTONS-1:0] click;
    logic                   right_click;

    assign code_ok = {1'b0, i_req.key_code} < 9'(NUM_KEYS);
    assign kidx    = i_req.key_code[KW-1:0];

    // Repeat deadline, summed without wrap
    assign deadline = {1'b0, r_last} + 33'(r_delay);
    assign rep_due  = (r_held != 8'd0) && ({1'b0, r_time} > deadline);

    // Delay shrink toward the floor
    assign shrunk    = r_delay - i_cfg.delay_step;
    assign delay_rep = (r_delay > i_cfg.delay_step)
                     ? ((shrunk > i_cfg.delay_floor) ? shrunk : i_cfg.delay_floor)
                     : r_delay;

    // Click edges
    assign click = r_btn_now & ~r_btn_before;
    generate
        if (NUM_BUTTONS > 1) begin : g_right
            assign right_click = click[1];
        end else begin : g_no_right
            assign right_click = 1'b0;
        end
    endgenerate

    // Next state
    always_comb begin
        n_key_now    = r_key_now;
        n_key_before = r_key_before;
        n_btn_now    = r_btn_now;
        n_btn_before = r_btn_before;
        n_held       = r_held;
        n_time       = r_time;
        n_last       = r_last;
        n_delay      = r_delay;
        if (i_req_valid) begin
            case (i_req.mode)
                ksr_pkg::MODE_TIME: begin
                    n_time = i_req.now_ms;
                end
                ksr_pkg::MODE_KEY: begin
                    if (code_ok) begin
                        if (i_req.pressed) begin
                            n_last = r_time;
                            n_held = i_req.key_code;
                        end else begin
                            n_delay = i_cfg.initial_delay;
                            if (r_held == i_req.key_code) begin
                                n_held = 8'd0;
                            end
                        end
                        n_key_now[kidx] = i_req.pressed;
                    end
                end
                ksr_pkg::MODE_BUTTON: begin
                    for (int b = 0; b < NUM_BUTTONS; b++) begin
                        if (int'(i_req.button_index) == b) begin
                            n_btn_now[b] = i_req.pressed;
                        end
                    end
                end
                ksr_pkg::MODE_TICK: begin
                    n_btn_before = r_btn_now;
                    if (rep_due) begin
                        n_key_before = '0;
                        n_last       = r_time;
                        n_delay      = delay_rep;
                    end else begin
                        n_key_before = r_key_now;
                    end
                end
                ksr_pkg::MODE_TAKE: begin
                    n_held = 8'd0;
                end
                default: begin
                end
            endcase
        end
    end

    // Result for the current request
    always_comb begin
        o_res = '0;
        if (i_req.mode == ksr_pkg::MODE_QUERY) begin
            o_res.key_is_down      = code_ok & r_key_now[kidx];
            o_res.key_just_pressed = code_ok & r_key_now[kidx] & ~r_key_before[kidx];
            o_res.left_clicked     = click[0];
            o_res.right_clicked    = right_click;
        end else if (i_req.mode == ksr_pkg::MODE_TAKE) begin
            o_res.pending_key = r_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_now    <= '0;
            r_key_before <= '0;
            r_btn_now    <= '0;
            r_btn_before <= '0;
            r_held       <= 8'd0;
            r_time       <= 32'd0;
            r_last       <= 32'd0;
            r_delay      <= ksr_pkg::RST_INITIAL_DELAY;
        end else begin
            r_key_now    <= n_key_now;
            r_key_before <= n_key_before;
            r_btn_now    <= n_btn_now;
            r_btn_before <= n_btn_before;
            r_held       <= n_held;
            r_time       <= n_time;
            r_last       <= n_last;
            r_delay      <= n_delay;
        end
    end

    // Held key always addresses a stored key
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_held} < 9'(NUM_KEYS))
        else $error("held key outside key store");

    // A tick without a repeat snapshots the current keys
    a_tick_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req.mode == ksr_pkg::MODE_TICK && !rep_due)
        |=> (r_key_before == $past(r_key_now)))
        else $error("tick did not copy key states");

    // A repeat restarts the repeat timer and loads the shrunk delay
    a_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req.mode == ksr_pkg::MODE_TICK && rep_due)
        |=> (r_key_before == '0) && (r_last == $past(r_time))
            && (r_delay == $past(delay_rep)))
        else $error("repeat tick update wrong");

    // Releasing the held key drops it and restores the delay
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req.mode == ksr_pkg::MODE_KEY && code_ok && !i_req.pressed
            && r_held == i_req.key_code)
        |=> (r_held == 8'd0) && (r_delay == $past(i_cfg.initial_delay)))
        else $error("release of held key not handled");

endmodule

[sim/key_state_typematic_repeat_checker.sv]
`timescale 1ns / 1ps

// Watches the request, config and result channels of the key state tracker,
// keeps its own copy of the key/button/repeat state and compares each result
// with the oldest prediction.
module key_state_typematic_repeat_checker
    import ksr_pkg::*;
#(
    parameter int NUM_KEYS    = 255,
    parameter int NUM_BUTTONS = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic [2:0]           i_mode,
    input  logic [7:0]           i_key_code,
    input  logic                 i_pressed,
    input  logic                 i_button_index,
    input  logic [31:0]          i_now_ms,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_done,
    input  logic                 i_key_is_down,
    input  logic                 i_key_just_pressed,
    input  logic                 i_left_clicked,
    input  logic                 i_right_clicked,
    input  logic [7:0]           i_pending_key,
    output int                   o_fail_count,
    output int                   o_due_count,
    output int                   o_checked_count
);

    // Shadow of the tracker state
    t_cfg                  delays;
    logic [NUM_KEYS-1:0]    keys_down;
    logic [NUM_KEYS-1:0]    keys_at_tick;
    logic [NUM_BUTTONS-1:0] buttons_down;
    logic [NUM_BUTTONS-1:0] buttons_at_tick;
    logic [7:0]             held_code;
    logic [31:0]            clock_ms;
    logic [31:0]            last_repeat_ms;
    logic [15:0]            repeat_wait;

    t_res due_results[$];
    t_req req;
    t_res want;

    initial begin
        o_fail_count    = 0;
        o_due_count     = 0;
        o_checked_count = 0;
    end

    // Apply one request to the shadow state and return the result it yields
    function automatic t_res advance_tracker(input t_req r);
        logic [32:0] deadline;
        logic [15:0] shrunk;
        t_res        res;
        res = '0;
        case (r.mode)
            MODE_TIME: begin
                clock_ms = r.now_ms;
            end
            MODE_KEY: begin
                if (int'(r.key_code) < NUM_KEYS) begin
                    if (r.pressed) begin
                        last_repeat_ms = clock_ms;
                        held_code      = r.key_code;
                    end else begin
                        repeat_wait = delays.initial_delay;
                        if (held_code == r.key_code) held_code = '0;
                    end
                    keys_down[r.key_code] = r.pressed;
                end
            end
            MODE_BUTTON: begin
                if (int'(r.button_index) < NUM_BUTTONS) buttons_down[r.button_index] = r.pressed;
            end
            MODE_TICK: begin
                deadline        = {1'b0, last_repeat_ms} + {17'b0, repeat_wait};
                buttons_at_tick = buttons_down;
                if (held_code != '0 && {1'b0, clock_ms} > deadline) begin
                    // repeat: held keys look newly pressed again
                    keys_at_tick   = '0;
                    last_repeat_ms = clock_ms;
                    if (repeat_wait > delays.delay_step) begin
                        shrunk      = repeat_wait - delays.delay_step;
                        repeat_wait = (shrunk > delays.delay_floor) ? shrunk : delays.delay_floor;
                    end
                end else begin
                    keys_at_tick = keys_down;
                end
            end
            MODE_QUERY: begin
                if (int'(r.key_code) < NUM_KEYS) begin
                    res.key_is_down      = keys_down[r.key_code];
                    res.key_just_pressed = keys_down[r.key_code] & ~keys_at_tick[r.key_code];
                end
                res.left_clicked  = buttons_down[0] & ~buttons_at_tick[0];
                if (NUM_BUTTONS > 1) res.right_clicked = buttons_down[1] & ~buttons_at_tick[1];
            end
            MODE_TAKE: begin
                res.pending_key = held_code;
                held_code       = '0;
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            if (o_fail_count < 40)
                $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            delays          = '{RST_INITIAL_DELAY, RST_DELAY_STEP, RST_DELAY_FLOOR};
            keys_down       = '0;
            keys_at_tick    = '0;
            buttons_down    = '0;
            buttons_at_tick = '0;
            held_code       = '0;
            clock_ms        = '0;
            last_repeat_ms  = '0;
            repeat_wait     = RST_INITIAL_DELAY;
            due_results.delete();
        end else begin
            // result side: compare with the oldest prediction
            if (i_done) begin
                if (due_results.size() == 0) begin
                    if (o_fail_count < 40)
                        $display("%0t ns: result with none expected, got pending key %0d",
                                 $time, i_pending_key);
                    o_fail_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("key_is_down", want.key_is_down, i_key_is_down);
                    check_field("key_just_pressed", want.key_just_pressed, i_key_just_pressed);
                    check_field("left_clicked", want.left_clicked, i_left_clicked);
                    check_field("right_clicked", want.right_clicked, i_right_clicked);
                    check_field("pending_key", want.pending_key, i_pending_key);
                    o_checked_count++;
                end
            end
            // config writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_INITIAL_DELAY: delays.initial_delay = i_cfg_data;
                    CFG_DELAY_STEP:    delays.delay_step    = i_cfg_data;
                    CFG_DELAY_FLOOR:   delays.delay_floor   = i_cfg_data;
                    default: ;
                endcase
            end
            // accepted request
            if (i_start && !i_busy) begin
                req = '{i_mode, i_key_code, i_pressed, i_button_index, i_now_ms};
                due_results.push_back(advance_tracker(req));
            end
        end
        o_due_count = due_results.size();
    end

endmodule

[sim/key_state_typematic_repeat_top_test.sv]
`timescale 1ns / 1ps

module key_state_typematic_repeat_top_test;
    import ksr_pkg::*;

    localparam int LIMIT_CYCLES = 200000;

    // Codes the block leaves unused
    localparam logic [2:0]           MODE_SPARE6 = 3'd6;
    localparam logic [2:0]           MODE_SPARE7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [2:0]           i_mode;
    logic [7:0]           i_key_code;
    logic                 i_pressed;
    logic                 i_button_index;
    logic [31:0]          i_now_ms;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;
    logic                 o_done;
    logic                 o_key_is_down;
    logic                 o_key_just_pressed;
    logic                 o_left_clicked;
    logic                 o_right_clicked;
    logic [7:0]           o_pending_key;

    int fail_count;
    int due_count;
    int checked_count;

    int          cycle_count;
    int          requests_sent;
    int          cfg_writes;
    int          settings_used;
    bit          gaps_on;
    logic [31:0] sim_ms;
    int          ms_span;

    key_state_typematic_repeat_top DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_mode             (i_mode),
        .i_key_code         (i_key_code),
        .i_pressed          (i_pressed),
        .i_button_index     (i_button_index),
        .i_now_ms           (i_now_ms),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_done             (o_done),
        .o_key_is_down      (o_key_is_down),
        .o_key_just_pressed (o_key_just_pressed),
        .o_left_clicked     (o_left_clicked),
        .o_right_clicked    (o_right_clicked),
        .o_pending_key      (o_pending_key)
    );

    key_state_typematic_repeat_checker checker_i (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_busy             (busy),
        .i_mode             (i_mode),
        .i_key_code         (i_key_code),
        .i_pressed          (i_pressed),
        .i_button_index     (i_button_index),
        .i_now_ms           (i_now_ms),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_done             (o_done),
        .i_key_is_down      (o_key_is_down),
        .i_key_just_pressed (o_key_just_pressed),
        .i_left_clicked     (o_left_clicked),
        .i_right_clicked    (o_right_clicked),
        .i_pending_key      (o_pending_key),
        .o_fail_count       (fail_count),
        .o_due_count        (due_count),
        .o_checked_count    (checked_count)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t ns: timeout with %0d results outstanding", $time, due_count);
            $display("simulation failed");
            $finish;
        end
    end

    // One request, with an optional idle burst ahead of it
    task automatic issue(input logic [2:0] mode, input logic [7:0] code, input logic pr,
                         input logic btn, input logic [31:0] now);
        int gap;
        if (gaps_on && $urandom_range(0, 6) == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        end
        @(negedge i_clk);
        start          <= 1'b1;
        i_mode         <= mode;
        i_key_code     <= code;
        i_pressed      <= pr;
        i_button_index <= btn;
        i_now_ms       <= now;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        requests_sent++;
    endtask

    // Hold off new requests until every result is back
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (due_count != 0) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // New delay settings, written only with nothing in flight
    task automatic reconfigure(input logic [15:0] init_d, input logic [15:0] step_d,
                               input logic [15:0] floor_d);
        drain();
        write_cfg(CFG_INITIAL_DELAY, init_d);
        write_cfg(CFG_DELAY_STEP, step_d);
        write_cfg(CFG_DELAY_FLOOR, floor_d);
        if ($urandom_range(0, 1) == 0) write_cfg(CFG_UNUSED, 16'($urandom()));
        ms_span = int'(init_d) / 3 + 40;
        settings_used++;
    endtask

    // Mostly typing sessions (time, press, ticks, queries, release), some noise
    task automatic run_phase(input int n_items, input bit with_gaps);
        int          stop_at;
        int          ticks;
        logic [7:0]  key;
        logic [2:0]  m;
        logic [31:0] now;
        gaps_on = with_gaps;
        stop_at = requests_sent + n_items;
        while (requests_sent < stop_at) begin
            if ($urandom_range(0, 9) < 7) begin
                key    = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(1, 254));
                sim_ms = sim_ms + 32'($urandom_range(0, 50));
                issue(MODE_TIME, 8'($urandom()), 1'($urandom()), 1'($urandom()), sim_ms);
                issue(MODE_KEY, key, 1'b1, 1'($urandom()), $urandom());
                ticks = $urandom_range(1, 8);
                repeat (ticks) begin
                    sim_ms = sim_ms + 32'($urandom_range(0, ms_span));
                    issue(MODE_TIME, 8'($urandom()), 1'($urandom()), 1'($urandom()), sim_ms);
                    issue(MODE_TICK, 8'($urandom()), 1'($urandom()), 1'($urandom()), $urandom());
                    issue(MODE_QUERY,
                          ($urandom_range(0, 3) == 0) ? 8'($urandom()) : key,
                          1'($urandom()), 1'($urandom()), $urandom());
                    if ($urandom_range(0, 3) == 0)
                        issue(MODE_BUTTON, 8'($urandom()), 1'($urandom()), 1'($urandom()),
                              $urandom());
                    if ($urandom_range(0, 9) == 0)
                        issue(MODE_KEY, 8'($urandom()), 1'($urandom()), 1'($urandom()),
                              $urandom());
                    if ($urandom_range(0, 9) == 0)
                        issue(MODE_TAKE, 8'($urandom()), 1'($urandom()), 1'($urandom()),
                              $urandom());
                end
                if ($urandom_range(0, 4) != 0)
                    issue(MODE_KEY, key, 1'b0, 1'($urandom()), $urandom());
                else if ($urandom_range(0, 1) == 0)
                    issue(MODE_KEY, 8'($urandom()), 1'b0, 1'($urandom()), $urandom());
            end else begin
                m   = 3'($urandom_range(0, 7));
                now = $urandom();
                if (m == MODE_TIME) sim_ms = now;
                issue(m, 8'($urandom()), 1'($urandom()), 1'($urandom()), now);
            end
        end
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_mode         = MODE_TIME;
        i_key_code     = '0;
        i_pressed      = 1'b0;
        i_button_index = 1'b0;
        i_now_ms       = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_INITIAL_DELAY;
        i_cfg_data     = '0;
        cycle_count    = 0;
        requests_sent  = 0;
        cfg_writes     = 0;
        settings_used  = 1;
        gaps_on        = 1'b0;
        sim_ms         = '0;
        ms_span        = 140;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: key code zero is stored but never held
        issue(MODE_QUERY, 8'd0, 1'b0, 1'b0, 32'd0);
        issue(MODE_KEY, 8'd0, 1'b1, 1'b0, 32'd0);
        issue(MODE_QUERY, 8'd0, 1'b0, 1'b0, 32'd0);
        issue(MODE_TICK, 8'd0, 1'b0, 1'b0, 32'd0);
        issue(MODE_QUERY, 8'd0, 1'b0, 1'b0, 32'd0);
        // both mouse buttons, click edge then steady
        issue(MODE_BUTTON, 8'd0, 1'b1, 1'b0, 32'd0);
        issue(MODE_BUTTON, 8'd0, 1'b1, 1'b1, 32'd0);
        issue(MODE_QUERY, 8'd1, 1'b0, 1'b0, 32'd0);
        issue(MODE_TICK, 8'd0, 1'b0, 1'b0, 32'd0);
        issue(MODE_QUERY, 8'd1, 1'b0, 1'b0, 32'd0);
        issue(MODE_BUTTON, 8'd0, 1'b0, 1'b1, 32'd0);
        // code beyond the key store
        issue(MODE_KEY, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
        issue(MODE_QUERY, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
        // repeat fires only strictly after the deadline, then take the held key
        issue(MODE_TIME, 8'd0, 1'b0, 1'b0, 32'd0);
        issue(MODE_KEY, 8'd254, 1'b1, 1'b0, 32'd0);
        issue(MODE_TIME, 8'd0, 1'b0, 1'b0, 32'd300);
        issue(MODE_TICK, 8'd0, 1'b0, 1'b0, 32'd0);
        issue(MODE_TIME, 8'd0, 1'b0, 1'b0, 32'd301);
        issue(MODE_TICK, 8'd0, 1'b0, 1'b0, 32'd0);
        issue(MODE_QUERY, 8'd254, 1'b0, 1'b0, 32'd0);
        issue(MODE_TAKE, 8'd0, 1'b0, 1'b0, 32'd0);
        issue(MODE_TAKE, 8'd0, 1'b0, 1'b0, 32'd0);
        issue(MODE_KEY, 8'd254, 1'b0, 1'b0, 32'd0);
        // unused modes with every field bit set
        issue(MODE_SPARE6, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
        issue(MODE_SPARE7, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
        // deadline past the top of the 32-bit time never fires
        issue(MODE_TIME, 8'd0, 1'b0, 1'b0, 32'hFFFF_FF00);
        issue(MODE_KEY, 8'h80, 1'b1, 1'b0, 32'd0);
        issue(MODE_TIME, 8'd0, 1'b0, 1'b0, 32'hFFFF_FFFF);
        issue(MODE_TICK, 8'd0, 1'b0, 1'b0, 32'd0);
        issue(MODE_QUERY, 8'h80, 1'b0, 1'b0, 32'd0);
        sim_ms = 32'hFFFF_FFFF;

        // Random phases across delay settings
        run_phase(150, 1'b1);
        reconfigure(16'd0, 16'd0, 16'd0);
        run_phase(160, 1'b1);
        reconfigure(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(160, 1'b1);
        reconfigure(16'd100, 16'd30, 16'd10);
        run_phase(160, 1'b0);
        reconfigure(16'hFFFF, 16'd0, 16'd0);
        run_phase(160, 1'b1);
        reconfigure(16'd0, 16'hFFFF, 16'hFFFF);
        run_phase(160, 1'b1);
        reconfigure(16'($urandom_range(0, 400)), 16'($urandom_range(0, 120)),
                    16'($urandom_range(0, 60)));
        run_phase(160, 1'b1);
        reconfigure(RST_INITIAL_DELAY, RST_DELAY_STEP, RST_DELAY_FLOOR);
        run_phase(160, 1'b0);

        // Let the last results come back
        drain();
        repeat (6) @(negedge i_clk);

        $display("Sent %0d requests over %0d delay settings with %0d config writes.",
                 requests_sent, settings_used, cfg_writes);
        $display("Checked %0d results, %0d mismatches.", checked_count, fail_count);
        if (fail_count == 0 && due_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
